[design/multi_queue_keyed_fifo_defines.svh]
// Assertion macros used by the keyed FIFO top level.
`ifndef MULTI_QUEUE_KEYED_FIFO_DEFINES_SVH
`define MULTI_QUEUE_KEYED_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MQKF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mqkf_pkg.sv]
// Types, constants and helpers for the multi-queue keyed FIFO.
package mqkf_pkg;

	// Sizing
	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int TOTAL_SLOTS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int REQ_W    = 3;
	localparam int QSEL_W   = 3;
	localparam int KEY_W    = 48;
	localparam int TIMER_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_Q = 2'd3;

	// Key kinds
	localparam logic KIND_IPV4 = 1'b0;
	localparam logic KIND_MAC  = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [QSEL_W-1:0]  queue_sel;
		logic               key_kind;
		logic [KEY_W-1:0]   key_value;
		logic [TIMER_W-1:0] timer_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                entry_kind_out;
		logic [KEY_W-1:0]    entry_key_out;
		logic [TIMER_W-1:0]  entry_timer_out;
		logic [COUNT_W-1:0]  queue_count;
	} rsp_t;

	// One stored queue entry
	typedef struct packed {
		logic               kind;
		logic [KEY_W-1:0]   key;
		logic [TIMER_W-1:0] timer;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_CMP,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_RESP
	} state_t;

	// IPv4 keys keep only their low 32 bits
	function automatic logic [KEY_W-1:0] norm_key(input logic kind, input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] res;
		res = key;
		if (kind == KIND_IPV4) begin
			res = {16'b0, key[31:0]};
		end
		return res;
	endfunction

endpackage

[design/multi_queue_keyed_fifo.sv]
// Top level of the multi-queue keyed FIFO: sequencer, entry memory and counts.
//
// channel   ports              handshake
// -------   -----------------  ---------------------------------------------
// request   start, busy, req   transaction taken at clk edge with start & !busy
// result    done, rsp          one-cycle strobe, always taken, no backpressure
//
// Push, clear, bad index and empty cases pass from dispatch straight to response.
// Find and remove visit one entry at a time through the single read port, in the
// scan and compare states; a removal then moves each later entry up, with a read
// in the move-read state and a write in the move-write state. Pop is a removal
// at position 0. busy stays high until the cycle after done.
// Reset clears only the sequencer state and the per-queue counts; entry storage needs no clearing.
`include "multi_queue_keyed_fifo_defines.svh"

module multi_queue_keyed_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mqkf_pkg::req_t  req,
	output logic            done,
	output mqkf_pkg::rsp_t  rsp
);

	localparam int AW = mqkf_pkg::ADDR_W;
	localparam int IW = mqkf_pkg::IDX_W;
	localparam int CW = mqkf_pkg::CNT_W;

	mqkf_pkg::state_t state_q, state_nxt;

	// Captured request
	logic [mqkf_pkg::REQ_W-1:0]   req_q;
	logic                         bad_q;
	logic [mqkf_pkg::QIDX_W-1:0]  q_q;
	logic                         kind_q;
	logic [mqkf_pkg::KEY_W-1:0]   key_q;
	logic [mqkf_pkg::TIMER_W-1:0] timer_q;

	// Walk state
	logic [IW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] fill_q [mqkf_pkg::NUM_QUEUES];

	// Result holding
	logic [mqkf_pkg::STATUS_W-1:0] status_q;
	mqkf_pkg::entry_t              res_entry_q;

	// Entry memory
	mqkf_pkg::entry_t mem [mqkf_pkg::TOTAL_SLOTS];
	mqkf_pkg::entry_t rdata_q;

	// Sequencer outputs
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	mqkf_pkg::entry_t mem_wdata;
	logic             fill_we;
	logic [CW-1:0]    fill_wdata;
	logic             status_we;
	logic [mqkf_pkg::STATUS_W-1:0] status_wdata;
	logic             latch_entry;
	logic             idx_inc;

	// Helpers
	logic [AW-1:0] base;
	logic [CW-1:0] cur_n;
	logic [CW:0]   pos1, pos2, nw;
	logic          is_match, is_head_op, is_removal;

	assign base  = AW'(q_q) * AW'(mqkf_pkg::QUEUE_DEPTH);
	assign cur_n = bad_q ? '0 : fill_q[q_q];
	assign pos1  = (CW+1)'(idx_q) + (CW+1)'(1);
	assign pos2  = (CW+1)'(idx_q) + (CW+1)'(2);
	assign nw    = (CW+1)'(n_q);
	assign is_match   = (rdata_q.kind == kind_q) && (rdata_q.key == key_q);
	assign is_head_op = (req_q == mqkf_pkg::REQ_POP) || (req_q == mqkf_pkg::REQ_PEEK);
	assign is_removal = (req_q == mqkf_pkg::REQ_POP) || (req_q == mqkf_pkg::REQ_REMOVE);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mqkf_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = mqkf_pkg::ST_DISPATCH;
				end
			end
			mqkf_pkg::ST_DISPATCH: begin
				state_nxt = mqkf_pkg::ST_RESP;
				if (!bad_q && cur_n != '0 &&
					(is_head_op || req_q == mqkf_pkg::REQ_FIND ||
					 req_q == mqkf_pkg::REQ_REMOVE)) begin
					state_nxt = mqkf_pkg::ST_SCAN;
				end
			end
			mqkf_pkg::ST_SCAN: state_nxt = mqkf_pkg::ST_CMP;
			mqkf_pkg::ST_CMP: begin
				if (is_head_op || is_match) begin
					if (is_removal && pos1 < nw) begin
						state_nxt = mqkf_pkg::ST_MOVE_RD;
					end else begin
						state_nxt = mqkf_pkg::ST_RESP;
					end
				end else if (pos1 >= nw) begin
					state_nxt = mqkf_pkg::ST_RESP;
				end else begin
					state_nxt = mqkf_pkg::ST_SCAN;
				end
			end
			mqkf_pkg::ST_MOVE_RD: state_nxt = mqkf_pkg::ST_MOVE_WR;
			mqkf_pkg::ST_MOVE_WR: begin
				if (pos2 < nw) begin
					state_nxt = mqkf_pkg::ST_MOVE_RD;
				end else begin
					state_nxt = mqkf_pkg::ST_RESP;
				end
			end
			mqkf_pkg::ST_RESP: state_nxt = mqkf_pkg::ST_IDLE;
			default: state_nxt = mqkf_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = base + AW'(idx_q);
		mem_raddr    = base + AW'(idx_q);
		mem_wdata    = rdata_q;
		fill_we      = 1'b0;
		fill_wdata   = n_q - CW'(1);
		status_we    = 1'b0;
		status_wdata = mqkf_pkg::STAT_OK;
		latch_entry  = 1'b0;
		idx_inc      = 1'b0;
		case (state_q)
			mqkf_pkg::ST_DISPATCH: begin
				if (bad_q) begin
					status_we    = 1'b1;
					status_wdata = mqkf_pkg::STAT_BAD_Q;
				end else begin
					case (req_q)
						mqkf_pkg::REQ_PUSH: begin
							if ((CW+1)'(cur_n) >= (CW+1)'(mqkf_pkg::QUEUE_DEPTH)) begin
								status_we    = 1'b1;
								status_wdata = mqkf_pkg::STAT_FULL;
							end else begin
								mem_we     = 1'b1;
								mem_waddr  = base + AW'(cur_n);
								mem_wdata  = '{kind: kind_q, key: key_q, timer: timer_q};
								fill_we    = 1'b1;
								fill_wdata = cur_n + CW'(1);
							end
						end
						mqkf_pkg::REQ_POP, mqkf_pkg::REQ_PEEK,
						mqkf_pkg::REQ_FIND, mqkf_pkg::REQ_REMOVE: begin
							if (cur_n == '0) begin
								status_we    = 1'b1;
								status_wdata = mqkf_pkg::STAT_EMPTY;
							end
						end
						mqkf_pkg::REQ_CLEAR: begin
							fill_we    = 1'b1;
							fill_wdata = '0;
						end
						default: ;
					endcase
				end
			end
			mqkf_pkg::ST_SCAN: mem_re = 1'b1;
			mqkf_pkg::ST_CMP: begin
				if (is_head_op || is_match) begin
					latch_entry = 1'b1;
					if (is_removal && pos1 >= nw) begin
						fill_we = 1'b1;
					end
				end else if (pos1 >= nw) begin
					status_we    = 1'b1;
					status_wdata = mqkf_pkg::STAT_EMPTY;
				end else begin
					idx_inc = 1'b1;
				end
			end
			mqkf_pkg::ST_MOVE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = base + AW'(idx_q) + AW'(1);
			end
			mqkf_pkg::ST_MOVE_WR: begin
				mem_we  = 1'b1;
				idx_inc = 1'b1;
				if (pos2 >= nw) begin
					fill_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqkf_pkg::ST_IDLE;
			for (int i = 0; i < mqkf_pkg::NUM_QUEUES; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (fill_we) begin
				fill_q[q_q] <= fill_wdata;
			end
		end
	end

	// Request capture and walk datapath
	always_ff @(posedge clk) begin
		if (state_q == mqkf_pkg::ST_IDLE && start) begin
			req_q       <= req.req_type;
			bad_q       <= (32'(req.queue_sel) >= 32'(mqkf_pkg::NUM_QUEUES));
			q_q         <= mqkf_pkg::QIDX_W'(req.queue_sel);
			kind_q      <= req.key_kind;
			key_q       <= mqkf_pkg::norm_key(req.key_kind, req.key_value);
			timer_q     <= req.timer_value;
			idx_q       <= '0;
			status_q    <= mqkf_pkg::STAT_OK;
			res_entry_q <= '0;
		end else begin
			if (idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (status_we) begin
				status_q <= status_wdata;
			end
			if (latch_entry) begin
				res_entry_q <= rdata_q;
			end
		end
		if (state_q == mqkf_pkg::ST_DISPATCH) begin
			n_q <= cur_n;
		end
	end

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Ports
	assign busy = (state_q != mqkf_pkg::ST_IDLE);
	assign done = (state_q == mqkf_pkg::ST_RESP);
	assign rsp.status          = status_q;
	assign rsp.entry_kind_out  = res_entry_q.kind;
	assign rsp.entry_key_out   = res_entry_q.key;
	assign rsp.entry_timer_out = res_entry_q.timer;
	assign rsp.queue_count     = mqkf_pkg::COUNT_W'(cur_n);

	// Checks
	`MQKF_ASSERT_NEXT(a_done_then_idle, done, !busy && !done, "sequencer did not return to idle")
	`MQKF_ASSERT_NEXT(a_start_takes, start && !busy, busy, "accepted transaction not taken up")
	`MQKF_ASSERT_SAME(a_fill_bound, busy && !bad_q, (CW+1)'(cur_n) <= (CW+1)'(mqkf_pkg::QUEUE_DEPTH), "queue count beyond depth")
	`MQKF_ASSERT_SAME(a_we_states, mem_we, state_q == mqkf_pkg::ST_DISPATCH || state_q == mqkf_pkg::ST_MOVE_WR, "memory write outside push or move")
	`MQKF_ASSERT_SAME(a_move_inside, state_q == mqkf_pkg::ST_MOVE_RD || state_q == mqkf_pkg::ST_MOVE_WR, pos1 < nw && is_removal, "entry move outside queue")

endmodule
